/* design/ccr_pkg.sv */
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared constants, datapath command codes and control/status types for the
// closed-ring Catmull-Rom point evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package ccr_pkg;

    localparam int MAX_POINTS = 64;
    localparam int FRAC_BITS  = 16;
    localparam int SCR_SHIFT  = FRAC_BITS + 13;

    localparam int PT_AW  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SEG_W  = 6;
    localparam int MOD_CW = $clog2(SEG_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MUL_W  = 20;
    localparam int PROD_W = 2 * MUL_W;
    localparam int Q_W    = MUL_W;
    localparam int ACC_W  = 36;
    localparam int DL_W   = 18;
    localparam int MAP_W  = 38;
    localparam int X_W    = 58;
    localparam int RZ_W   = 26;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM_FACTOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROAD_WIDTH    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MARKER_WIDTH  = 3'd7;

    typedef enum logic [5:0] {
        OP_NOP,
        OP_LATCH,
        OP_MOD,
        OP_RD0,
        OP_RD1,
        OP_RD2,
        OP_RD3,
        OP_RZ,
        OP_C1X,
        OP_C2X,
        OP_C1Y,
        OP_C2Y,
        OP_CULL,
        OP_TT,
        OP_TTT,
        OP_Q,
        OP_SX0,
        OP_SX1,
        OP_SX2,
        OP_SX3,
        OP_SY0,
        OP_SY1,
        OP_SY2,
        OP_SY3,
        OP_D,
        OP_XL,
        OP_XH,
        OP_YL,
        OP_YH,
        OP_VIEW,
        OP_OUT
    } ccr_op_t;

    typedef struct packed {
        ccr_op_t op;
        logic    skip;
    } ccr_cmd_t;

    typedef struct packed {
        logic empty;
        logic cull;
    } ccr_stat_t;

endpackage

`default_nettype wire

/* design/ccr_dp.sv */
// ----------------------------------------------------------------------------
// ccr_dp
// Datapath: configuration registers, control point ring memory, segment
// modulo unit, shared multiplier with accumulators, cull and view tests.
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_dp
    import ccr_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ccr_cmd_t                     cmd,
    output ccr_stat_t                         stat,
    input  wire logic                         cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                         mode,
    input  wire logic [5:0]                   point_index,
    input  wire logic signed [15:0]           point_x,
    input  wire logic signed [15:0]           point_y,
    input  wire logic [SEG_W-1:0]             segment,
    input  wire logic [15:0]                  fraction,
    input  wire logic signed [15:0]           pivot_x,
    input  wire logic signed [15:0]           pivot_y,
    output logic signed [15:0]                screen_x,
    output logic signed [15:0]                screen_y,
    output logic                              skipped,
    output logic                              in_view,
    output logic                              draw_enable
);

    function automatic logic signed [16:0] sub16(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
        sub16 = 17'(a) - 17'(b);
    endfunction

    function automatic logic beyond(input logic signed [MAP_W-1:0] a,
                                    input logic signed [MAP_W-1:0] b,
                                    input logic signed [MAP_W-1:0] s,
                                    input logic signed [MAP_W-1:0] lim);
        beyond = (((a + s) < 0) && ((b + s) < 0)) ||
                 (((a - s) > lim) && ((b - s) > lim));
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [X_W-1:0] v);
        if (v > X_W'(32767))
            sat16 = 16'sd32767;
        else if (v < -X_W'(32768))
            sat16 = -16'sd32768;
        else
            sat16 = v[15:0];
    endfunction

    function automatic logic [1:0] phase_step(input logic [1:0] ph);
        if (ph == 2'd0)
            phase_step = 2'd3;
        else if (ph > 2'd1)
            phase_step = ph - 2'd1;
        else
            phase_step = ph;
    endfunction

    logic [6:0]               point_count_reg;
    logic signed [15:0]       camera_x_reg;
    logic signed [15:0]       camera_y_reg;
    logic [15:0]              zoom_reg;
    logic [12:0]              win_w_reg;
    logic [12:0]              win_h_reg;
    logic [9:0]               road_w_reg;
    logic [9:0]               marker_w_reg;
    logic [1:0]               draw_phase_reg;

    logic [CNT_W-1:0]         n_cnt;
    logic [15:0]              frac_reg;
    logic signed [15:0]       pivx_reg;
    logic signed [15:0]       pivy_reg;
    logic signed [16:0]       pcx_reg;
    logic signed [16:0]       pcy_reg;
    logic [SEG_W-1:0]         seg_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic [CNT_W-1:0]         rem_next;
    logic [CNT_W:0]           rem_sh;
    logic [PT_AW-1:0]         ptr_reg;
    logic [PT_AW-1:0]         rd_addr;
    logic [CNT_W-1:0]         ptr_inc;
    logic [PT_AW-1:0]         ptr_adv;
    logic [PT_AW-1:0]         wr_addr;
    logic                     wr_en;

    logic signed [15:0]       ring_x [MAX_POINTS];
    logic signed [15:0]       ring_y [MAX_POINTS];
    logic signed [15:0]       rd_x_reg;
    logic signed [15:0]       rd_y_reg;
    logic signed [15:0]       ptx_reg [4];
    logic signed [15:0]       pty_reg [4];

    ccr_op_t                  op_d_reg;
    logic signed [MUL_W-1:0]  ma;
    logic signed [MUL_W-1:0]  mb;
    logic signed [MUL_W-1:0]  zoom_op;
    logic signed [PROD_W-1:0] prod_reg;

    logic [RZ_W-1:0]          rz_reg;
    logic signed [MAP_W-1:0]  c_reg [4];
    logic                     cull_reg;
    logic [15:0]              tt_reg;
    logic [15:0]              ttt_reg;
    logic signed [Q_W-1:0]    q_reg [4];
    logic signed [Q_W-1:0]    ts;
    logic signed [Q_W-1:0]    tts;
    logic signed [Q_W-1:0]    ttts;
    logic signed [ACC_W-1:0]  sx_reg;
    logic signed [ACC_W-1:0]  sy_reg;
    logic signed [ACC_W-1:0]  dx_reg;
    logic signed [ACC_W-1:0]  dy_reg;
    logic signed [X_W-1:0]    xr_reg;
    logic signed [X_W-1:0]    yr_reg;

    logic signed [MAP_W-1:0]  s4;
    logic signed [MAP_W-1:0]  limx;
    logic signed [MAP_W-1:0]  limy;
    logic signed [X_W-1:0]    margin;
    logic signed [X_W-1:0]    winx;
    logic signed [X_W-1:0]    winy;
    logic                     view_now;
    logic signed [15:0]       res_x_reg;
    logic signed [15:0]       res_y_reg;
    logic                     res_iv_reg;
    logic [1:0]               ph_step;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
            camera_x_reg    <= '0;
            camera_y_reg    <= '0;
            zoom_reg        <= 16'd4096;
            win_w_reg       <= 13'd1920;
            win_h_reg       <= 13'd1080;
            road_w_reg      <= '0;
            marker_w_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_POINT_COUNT:   point_count_reg <= cfg_data[6:0];
                REG_CAMERA_X:      camera_x_reg    <= cfg_data;
                REG_CAMERA_Y:      camera_y_reg    <= cfg_data;
                REG_ZOOM_FACTOR:   zoom_reg        <= cfg_data;
                REG_WINDOW_WIDTH:  win_w_reg       <= cfg_data[12:0];
                REG_WINDOW_HEIGHT: win_h_reg       <= cfg_data[12:0];
                REG_ROAD_WIDTH:    road_w_reg      <= cfg_data[9:0];
                REG_MARKER_WIDTH:  marker_w_reg    <= cfg_data[9:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (32'(point_count_reg) > MAX_POINTS)
            n_cnt = CNT_W'(MAX_POINTS);
        else
            n_cnt = CNT_W'(point_count_reg);
    end

    assign stat.empty = (n_cnt == '0);
    assign stat.cull  = cull_reg;

    // segment modulo, one bit a step
    always_comb
    begin
        rem_sh = {rem_reg, seg_reg[SEG_W-1]};
        if (rem_sh >= {1'b0, n_cnt})
            rem_next = CNT_W'(rem_sh - {1'b0, n_cnt});
        else
            rem_next = CNT_W'(rem_sh);
    end

    // ring addressing
    always_comb
    begin
        rd_addr = (cmd.op == OP_RD0) ? rem_reg[PT_AW-1:0] : ptr_reg;
        ptr_inc = CNT_W'(rd_addr) + CNT_W'(1);
        ptr_adv = (ptr_inc == n_cnt) ? '0 : ptr_inc[PT_AW-1:0];
    end

    assign wr_addr = PT_AW'(point_index);
    assign wr_en   = (cmd.op == OP_LATCH) && !mode && (32'(point_index) < MAX_POINTS);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_x[wr_addr] <= point_x;
            ring_y[wr_addr] <= point_y;
        end
        rd_x_reg <= ring_x[rd_addr];
        rd_y_reg <= ring_y[rd_addr];
    end

    // shared multiplier operand select
    assign zoom_op = MUL_W'($signed({1'b0, zoom_reg}));

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (cmd.op)
            OP_RZ:
            begin
                ma = MUL_W'($signed({1'b0, road_w_reg}));
                mb = zoom_op;
            end
            OP_C1X:
            begin
                ma = MUL_W'(sub16(ptx_reg[1], pivx_reg));
                mb = zoom_op;
            end
            OP_C2X:
            begin
                ma = MUL_W'(sub16(ptx_reg[2], pivx_reg));
                mb = zoom_op;
            end
            OP_C1Y:
            begin
                ma = MUL_W'(sub16(pty_reg[1], pivy_reg));
                mb = zoom_op;
            end
            OP_C2Y:
            begin
                ma = MUL_W'(sub16(pty_reg[2], pivy_reg));
                mb = zoom_op;
            end
            OP_TT:
            begin
                ma = MUL_W'($signed({1'b0, frac_reg}));
                mb = MUL_W'($signed({1'b0, frac_reg}));
            end
            OP_TTT:
            begin
                ma = MUL_W'($signed({1'b0, tt_reg}));
                mb = MUL_W'($signed({1'b0, frac_reg}));
            end
            OP_SX0:
            begin
                ma = MUL_W'(ptx_reg[0]);
                mb = q_reg[0];
            end
            OP_SX1:
            begin
                ma = MUL_W'(ptx_reg[1]);
                mb = q_reg[1];
            end
            OP_SX2:
            begin
                ma = MUL_W'(ptx_reg[2]);
                mb = q_reg[2];
            end
            OP_SX3:
            begin
                ma = MUL_W'(ptx_reg[3]);
                mb = q_reg[3];
            end
            OP_SY0:
            begin
                ma = MUL_W'(pty_reg[0]);
                mb = q_reg[0];
            end
            OP_SY1:
            begin
                ma = MUL_W'(pty_reg[1]);
                mb = q_reg[1];
            end
            OP_SY2:
            begin
                ma = MUL_W'(pty_reg[2]);
                mb = q_reg[2];
            end
            OP_SY3:
            begin
                ma = MUL_W'(pty_reg[3]);
                mb = q_reg[3];
            end
            OP_XL:
            begin
                ma = MUL_W'($signed({1'b0, dx_reg[DL_W-1:0]}));
                mb = zoom_op;
            end
            OP_XH:
            begin
                ma = MUL_W'($signed(dx_reg[ACC_W-1:DL_W]));
                mb = zoom_op;
            end
            OP_YL:
            begin
                ma = MUL_W'($signed({1'b0, dy_reg[DL_W-1:0]}));
                mb = zoom_op;
            end
            OP_YH:
            begin
                ma = MUL_W'($signed(dy_reg[ACC_W-1:DL_W]));
                mb = zoom_op;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_d_reg <= OP_NOP;
        else
            op_d_reg <= cmd.op;
    end

    // consume the previous beat's read data or product
    always_ff @(posedge clk)
    begin
        unique case (op_d_reg)
            OP_RD0:
            begin
                ptx_reg[0] <= rd_x_reg;
                pty_reg[0] <= rd_y_reg;
            end
            OP_RD1:
            begin
                ptx_reg[1] <= rd_x_reg;
                pty_reg[1] <= rd_y_reg;
            end
            OP_RD2:
            begin
                ptx_reg[2] <= rd_x_reg;
                pty_reg[2] <= rd_y_reg;
            end
            OP_RD3:
            begin
                ptx_reg[3] <= rd_x_reg;
                pty_reg[3] <= rd_y_reg;
            end
            OP_RZ:  rz_reg   <= prod_reg[RZ_W-1:0];
            OP_C1X: c_reg[0] <= (MAP_W'(pcx_reg) <<< 12) + MAP_W'(prod_reg);
            OP_C2X: c_reg[1] <= (MAP_W'(pcx_reg) <<< 12) + MAP_W'(prod_reg);
            OP_C1Y: c_reg[2] <= (MAP_W'(pcy_reg) <<< 12) + MAP_W'(prod_reg);
            OP_C2Y: c_reg[3] <= (MAP_W'(pcy_reg) <<< 12) + MAP_W'(prod_reg);
            OP_TT:  tt_reg   <= prod_reg[2*FRAC_BITS-1:FRAC_BITS];
            OP_TTT: ttt_reg  <= prod_reg[2*FRAC_BITS-1:FRAC_BITS];
            OP_SX0: sx_reg   <= ACC_W'(prod_reg);
            OP_SX1, OP_SX2, OP_SX3:
                    sx_reg   <= sx_reg + ACC_W'(prod_reg);
            OP_SY0: sy_reg   <= ACC_W'(prod_reg);
            OP_SY1, OP_SY2, OP_SY3:
                    sy_reg   <= sy_reg + ACC_W'(prod_reg);
            OP_XL:  xr_reg   <= (X_W'(pcx_reg) <<< SCR_SHIFT) + X_W'(prod_reg);
            OP_XH:  xr_reg   <= xr_reg + (X_W'(prod_reg) <<< DL_W);
            OP_YL:  yr_reg   <= (X_W'(pcy_reg) <<< SCR_SHIFT) + X_W'(prod_reg);
            OP_YH:  yr_reg   <= yr_reg + (X_W'(prod_reg) <<< DL_W);
            default: ;
        endcase
    end

    // basis weights, cull limits, view limits
    always_comb
    begin
        ts   = Q_W'($signed({1'b0, frac_reg}));
        tts  = Q_W'($signed({1'b0, tt_reg}));
        ttts = Q_W'($signed({1'b0, ttt_reg}));
        s4   = MAP_W'($signed({1'b0, rz_reg[RZ_W-1:13]})) <<< 12;
        limx = MAP_W'($signed({1'b0, win_w_reg})) <<< 12;
        limy = MAP_W'($signed({1'b0, win_h_reg})) <<< 12;
        margin = X_W'($signed({1'b0, rz_reg})) <<< FRAC_BITS;
        winx   = X_W'($signed({1'b0, win_w_reg})) <<< SCR_SHIFT;
        winy   = X_W'($signed({1'b0, win_h_reg})) <<< SCR_SHIFT;
        view_now = ((xr_reg + margin) >= 0) && (xr_reg < (winx + margin)) &&
                   ((yr_reg + margin) >= 0) && (yr_reg < (winy + margin));
        ph_step = phase_step(draw_phase_reg);
    end

    // per-item working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LATCH:
            begin
                frac_reg <= fraction;
                pivx_reg <= pivot_x;
                pivy_reg <= pivot_y;
                pcx_reg  <= sub16(pivot_x, camera_x_reg);
                pcy_reg  <= sub16(pivot_y, camera_y_reg);
                seg_reg  <= segment;
                rem_reg  <= '0;
            end
            OP_MOD:
            begin
                rem_reg <= rem_next;
                seg_reg <= {seg_reg[SEG_W-2:0], 1'b0};
            end
            OP_RD0, OP_RD1, OP_RD2, OP_RD3:
                ptr_reg <= ptr_adv;
            OP_CULL:
                cull_reg <= beyond(c_reg[0], c_reg[1], s4, limx) ||
                            beyond(c_reg[2], c_reg[3], s4, limy);
            OP_Q:
            begin
                q_reg[0] <= (tts <<< 1) - ttts - ts;
                q_reg[1] <= (ttts <<< 1) + ttts - ((tts <<< 2) + tts) +
                            (Q_W'(2) <<< FRAC_BITS);
                q_reg[2] <= (tts <<< 2) + ts - ((ttts <<< 1) + ttts);
                q_reg[3] <= ttts - tts;
            end
            OP_D:
            begin
                dx_reg <= sx_reg + (ACC_W'($signed({1'b0, marker_w_reg})) <<< FRAC_BITS)
                          - (ACC_W'(pivx_reg) <<< (FRAC_BITS + 1));
                dy_reg <= sy_reg + (ACC_W'($signed({1'b0, marker_w_reg})) <<< FRAC_BITS)
                          - (ACC_W'(pivy_reg) <<< (FRAC_BITS + 1));
            end
            OP_VIEW:
            begin
                res_x_reg  <= sat16(xr_reg >>> SCR_SHIFT);
                res_y_reg  <= sat16(yr_reg >>> SCR_SHIFT);
                res_iv_reg <= view_now;
            end
            OP_OUT:
            begin
                if (cmd.skip)
                begin
                    screen_x    <= '0;
                    screen_y    <= '0;
                    skipped     <= 1'b1;
                    in_view     <= 1'b0;
                    draw_enable <= 1'b0;
                end
                else
                begin
                    screen_x    <= res_x_reg;
                    screen_y    <= res_y_reg;
                    skipped     <= 1'b0;
                    in_view     <= res_iv_reg;
                    draw_enable <= res_iv_reg && (ph_step == 2'd1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            draw_phase_reg <= '0;
        else if (cmd.op == OP_OUT)
        begin
            if (cmd.skip || !res_iv_reg)
                draw_phase_reg <= '0;
            else
                draw_phase_reg <= ph_step;
        end
    end

    a_rem_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_RD0) |-> (rem_reg < n_cnt))
        else $error("segment remainder outside ring");

    a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == OP_RD1) || (cmd.op == OP_RD2) || (cmd.op == OP_RD3))
        |-> (CNT_W'(ptr_reg) < n_cnt))
        else $error("ring pointer outside ring");

    a_skip_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == OP_OUT) && cmd.skip) |=> (draw_phase_reg == 2'd0))
        else $error("skipped segment left draw phase set");

endmodule

`default_nettype wire

/* design/ccr_ctrl.sv */
// ----------------------------------------------------------------------------
// ccr_ctrl
// Controller: accepts beats, sequences the datapath through modulo, ring
// reads, cull test, basis, weighted sums, mapping and view test, and hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_ctrl
    import ccr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      mode,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output ccr_cmd_t       cmd,
    input  wire ccr_stat_t stat
);

    typedef enum logic [5:0] {
        S_IDLE, S_MOD,
        S_RD0, S_RD1, S_RD2, S_RD3,
        S_RZ, S_C1X, S_C2X, S_C1Y, S_C2Y, S_CDRN, S_CULL, S_CHK,
        S_TT, S_TW0, S_TTT, S_TW1, S_Q,
        S_SX0, S_SX1, S_SX2, S_SX3, S_SY0, S_SY1, S_SY2, S_SY3, S_SDRN,
        S_D, S_XL, S_XH, S_YL, S_YH, S_XDRN, S_VIEW, S_DONE
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [MOD_CW-1:0]   cnt_reg;
    logic [MOD_CW-1:0]   cnt_next;
    logic                skip_reg;
    logic                skip_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        skip_next      = skip_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NOP;
        cmd.skip       = skip_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LATCH;
                    if (mode)
                    begin
                        cnt_next = '0;
                        if (stat.empty)
                        begin
                            skip_next  = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            skip_next  = 1'b0;
                            state_next = S_MOD;
                        end
                    end
                end
            end
            S_MOD:
            begin
                cmd.op = OP_MOD;
                if (cnt_reg == MOD_CW'(SEG_W - 1))
                    state_next = S_RD0;
                else
                    cnt_next = cnt_reg + MOD_CW'(1);
            end
            S_RD0:  begin cmd.op = OP_RD0;  state_next = S_RD1;  end
            S_RD1:  begin cmd.op = OP_RD1;  state_next = S_RD2;  end
            S_RD2:  begin cmd.op = OP_RD2;  state_next = S_RD3;  end
            S_RD3:  begin cmd.op = OP_RD3;  state_next = S_RZ;   end
            S_RZ:   begin cmd.op = OP_RZ;   state_next = S_C1X;  end
            S_C1X:  begin cmd.op = OP_C1X;  state_next = S_C2X;  end
            S_C2X:  begin cmd.op = OP_C2X;  state_next = S_C1Y;  end
            S_C1Y:  begin cmd.op = OP_C1Y;  state_next = S_C2Y;  end
            S_C2Y:  begin cmd.op = OP_C2Y;  state_next = S_CDRN; end
            S_CDRN: state_next = S_CULL;
            S_CULL: begin cmd.op = OP_CULL; state_next = S_CHK;  end
            S_CHK:
            begin
                if (stat.cull)
                begin
                    skip_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                    state_next = S_TT;
            end
            S_TT:   begin cmd.op = OP_TT;   state_next = S_TW0;  end
            S_TW0:  state_next = S_TTT;
            S_TTT:  begin cmd.op = OP_TTT;  state_next = S_TW1;  end
            S_TW1:  state_next = S_Q;
            S_Q:    begin cmd.op = OP_Q;    state_next = S_SX0;  end
            S_SX0:  begin cmd.op = OP_SX0;  state_next = S_SX1;  end
            S_SX1:  begin cmd.op = OP_SX1;  state_next = S_SX2;  end
            S_SX2:  begin cmd.op = OP_SX2;  state_next = S_SX3;  end
            S_SX3:  begin cmd.op = OP_SX3;  state_next = S_SY0;  end
            S_SY0:  begin cmd.op = OP_SY0;  state_next = S_SY1;  end
            S_SY1:  begin cmd.op = OP_SY1;  state_next = S_SY2;  end
            S_SY2:  begin cmd.op = OP_SY2;  state_next = S_SY3;  end
            S_SY3:  begin cmd.op = OP_SY3;  state_next = S_SDRN; end
            S_SDRN: state_next = S_D;
            S_D:    begin cmd.op = OP_D;    state_next = S_XL;   end
            S_XL:   begin cmd.op = OP_XL;   state_next = S_XH;   end
            S_XH:   begin cmd.op = OP_XH;   state_next = S_YL;   end
            S_YL:   begin cmd.op = OP_YL;   state_next = S_YH;   end
            S_YH:   begin cmd.op = OP_YH;   state_next = S_XDRN; end
            S_XDRN: state_next = S_VIEW;
            S_VIEW: begin cmd.op = OP_VIEW; state_next = S_DONE; end
            S_DONE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |=> out_valid_reg)
        else $error("result loaded but not presented");

endmodule

`default_nettype wire

/* design/closed_catmull_rom_point_eval_top.sv */
// ----------------------------------------------------------------------------
// closed_catmull_rom_point_eval_top
// Closed-ring uniform Catmull-Rom curve point evaluator with camera offset,
// zoom about a pivot, on-screen culling and a draw warm-up flag.
//
// Channels: the input channel (in_valid/in_ready) carries one beat per item;
// mode 0 writes a control point, mode 1 evaluates a curve point. The output
// channel (out_valid/out_ready) carries one beat per evaluate item. The
// configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready and writes one register per beat.
// Sequencing: a write beat leaves the block idle and ready for the next beat.
// An evaluate beat runs to its result, ending early for a culled segment or
// an empty ring; it is paced by the single shared multiplier (19 products),
// the 6-step segment modulo and the ring memory reads. One item is in work at
// a time; the next beat is accepted as soon as the result is loaded.
// Stall: the result register holds while out_ready is low; the block accepts
// the next beat and stalls only when a new result is ready to load.
// Reset: configuration returns to its defaults and the draw phase to zero;
// ring contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module closed_catmull_rom_point_eval_top
    import ccr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   mode,
    input  wire logic [5:0]             point_index,
    input  wire logic signed [15:0]     point_x,
    input  wire logic signed [15:0]     point_y,
    input  wire logic [5:0]             segment,
    input  wire logic [15:0]            fraction,
    input  wire logic signed [15:0]     pivot_x,
    input  wire logic signed [15:0]     pivot_y,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [15:0]          screen_x,
    output logic signed [15:0]          screen_y,
    output logic                        skipped,
    output logic                        in_view,
    output logic                        draw_enable,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    ccr_cmd_t  cmd;
    ccr_stat_t stat;

    assign cfg_ready = 1'b1;

    ccr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .mode      (mode),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ccr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mode        (mode),
        .point_index (point_index),
        .point_x     (point_x),
        .point_y     (point_y),
        .segment     (segment),
        .fraction    (fraction),
        .pivot_x     (pivot_x),
        .pivot_y     (pivot_y),
        .screen_x    (screen_x),
        .screen_y    (screen_y),
        .skipped     (skipped),
        .in_view     (in_view),
        .draw_enable (draw_enable)
    );

endmodule

`default_nettype wire
